/* rtl/core/csvt_pkg.sv */
// Package: shared types, character codes and the field classifier for the CSV tokenizer.
package csvt_pkg;

  localparam logic [7:0] CH_QUOTE   = 8'd34;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_DOLLAR  = 8'd36;
  localparam logic [7:0] CH_DOT     = 8'd46;
  localparam logic [7:0] CH_COMMA   = 8'd44;
  localparam logic [7:0] SEP_RESET  = 8'd44;

  typedef enum logic [1:0] {
    QS_START  = 2'd0,
    QS_PLAIN  = 2'd1,
    QS_QUOTED = 2'd2,
    QS_AFTER  = 2'd3
  } qstate_e;

  typedef enum logic [2:0] {
    CL_EMPTY = 3'd0,
    CL_INT   = 3'd1,
    CL_FLOAT = 3'd2,
    CL_TEXT  = 3'd3,
    CL_MONEY = 3'd4,
    CL_CODE  = 3'd5
  } cls_e;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // What the current word does to the field
  typedef struct packed {
    logic take;   // content byte
    logic fin;    // field end
    logic rec;    // record end with fin
    logic err;    // unterminated quote at end of input
    logic clr;    // silent return to record start
  } act_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [7:0]  fld_num;
    cls_e        cls;
    logic [10:0] size;
    logic        rec_end;
    logic        clipped;
    logic        ovf;
  } res_t;

  function automatic cls_e next_class(cls_e cls, logic [7:0] b);
    logic letter;
    logic digit;
    cls_e nc;
    letter = ((b >= 8'd97) && (b <= 8'd122)) || ((b >= 8'd65) && (b <= 8'd90));
    digit  = (b >= 8'd48) && (b <= 8'd57);
    nc     = cls;
    priority if (letter) begin
      if (cls == CL_EMPTY) nc = CL_TEXT;
      else if (cls == CL_INT || cls == CL_FLOAT || cls == CL_MONEY) nc = CL_CODE;
    end else if (digit) begin
      if (cls == CL_EMPTY) nc = CL_INT;
      else if (cls == CL_TEXT) nc = CL_CODE;
    end else if (b == CH_DOT || b == CH_COMMA) begin
      if (cls == CL_EMPTY || cls == CL_INT) nc = CL_FLOAT;
      else if (cls == CL_TEXT || cls == CL_FLOAT) nc = CL_CODE;
    end else if (b == CH_DOLLAR) begin
      nc = (cls == CL_EMPTY) ? CL_MONEY : CL_CODE;
    end else begin
      nc = cls;
    end
    return nc;
  endfunction

endpackage

/* rtl/core/csvt_core.sv */
// Tokenizer core: quote state, running class, length and field index, one word per step.
module csvt_core #(
  parameter int MAX_FIELDS    = 128,
  parameter int MAX_FIELD_LEN = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      byte_i,
  input  logic            eoi_i,
  input  logic [7:0]      sep_i,
  output logic            res_vld_o,
  output csvt_pkg::res_t  res_o
);
  import csvt_pkg::*;

  localparam int FW = $clog2(MAX_FIELDS + 1);
  localparam int LW = $clog2(MAX_FIELD_LEN + 1);

  qstate_e       qs_q, qs_d;
  cls_e          cls_q, cls_d;
  logic [LW-1:0] len_q, len_d;
  logic [FW-1:0] fld_q, fld_d;
  logic          clip_q, clip_d;
  act_t          act;

  logic          len_full;
  logic          fld_full;
  cls_e          cls_byte;
  logic [LW-1:0] len_inc;
  logic [LW-1:0] len_rep;
  logic [LW+10:0] len_ext;
  logic [FW+7:0]  fld_ext;

  assign len_full = (len_q >= LW'(MAX_FIELD_LEN));
  assign fld_full = (fld_q >= FW'(MAX_FIELDS));
  assign cls_byte = next_class(cls_q, byte_i);
  assign len_inc  = len_q + LW'(1);

  // next quote state and action
  always_comb begin
    act  = '0;
    qs_d = qs_q;
    if (eoi_i) begin
      qs_d = QS_START;
      if (qs_q == QS_QUOTED) begin
        act.err = 1'b1;
      end else if (qs_q == QS_START && fld_q == '0) begin
        act.clr = 1'b1;
      end else begin
        act.fin = 1'b1;
        act.rec = 1'b1;
      end
    end else begin
      unique case (qs_q)
        QS_START: begin
          if (byte_i == sep_i) begin
            act.fin = 1'b1;
          end else if (byte_i == CH_NEWLINE) begin
            act.fin = 1'b1;
            act.rec = 1'b1;
          end else if (byte_i == CH_QUOTE) begin
            qs_d = QS_QUOTED;
          end else begin
            qs_d     = QS_PLAIN;
            act.take = 1'b1;
          end
        end
        QS_PLAIN: begin
          if (byte_i == sep_i) begin
            act.fin = 1'b1;
          end else if (byte_i == CH_NEWLINE) begin
            act.fin = 1'b1;
            act.rec = 1'b1;
          end else begin
            act.take = 1'b1;
          end
        end
        QS_QUOTED: begin
          if (byte_i == CH_QUOTE) qs_d = QS_AFTER;
          else act.take = 1'b1;
        end
        QS_AFTER: begin
          if (byte_i == sep_i) begin
            act.fin = 1'b1;
          end else if (byte_i == CH_NEWLINE) begin
            act.fin = 1'b1;
            act.rec = 1'b1;
          end else if (byte_i == CH_QUOTE) begin
            qs_d     = QS_QUOTED;
            act.take = 1'b1;
          end
        end
        default: qs_d = QS_START;
      endcase
      if (act.fin) qs_d = QS_START;
    end
  end

  // field data and result
  always_comb begin
    cls_d     = cls_q;
    len_d     = len_q;
    fld_d     = fld_q;
    clip_d    = clip_q;
    res_vld_o = 1'b0;
    len_rep   = len_q;
    res_o     = '0;
    res_o.kind    = KIND_BYTE;
    res_o.cls     = cls_q;
    res_o.clipped = clip_q;
    res_o.ovf     = fld_full;
    if (act.take) begin
      res_o.clipped = 1'b0;
      if (len_full) begin
        clip_d = 1'b1;
      end else begin
        len_d      = len_inc;
        len_rep    = len_inc;
        cls_d      = cls_byte;
        res_o.cls  = cls_byte;
        res_o.data = byte_i;
        res_vld_o  = 1'b1;
      end
    end
    if (act.fin || act.err || act.clr) begin
      cls_d  = CL_EMPTY;
      len_d  = '0;
      clip_d = 1'b0;
    end
    if (act.fin) begin
      res_vld_o     = 1'b1;
      res_o.kind    = KIND_FIELD;
      res_o.rec_end = act.rec;
      if (act.rec) fld_d = '0;
      else if (!fld_full) fld_d = fld_q + FW'(1);
    end
    if (act.err) begin
      res_vld_o     = 1'b1;
      res_o.kind    = KIND_ERROR;
      res_o.rec_end = 1'b1;
      fld_d         = '0;
    end
    len_ext       = {11'b0, len_rep};
    fld_ext       = {8'b0, fld_q};
    res_o.size    = len_ext[10:0];
    res_o.fld_num = fld_ext[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qs_q   <= QS_START;
      cls_q  <= CL_EMPTY;
      len_q  <= '0;
      fld_q  <= '0;
      clip_q <= 1'b0;
    end else if (step_i) begin
      qs_q   <= qs_d;
      cls_q  <= cls_d;
      len_q  <= len_d;
      fld_q  <= fld_d;
      clip_q <= clip_d;
    end
  end

  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(MAX_FIELD_LEN)) else $error("field length past limit");

  a_fld_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fld_q <= FW'(MAX_FIELDS)) else $error("field index past limit");

  a_start_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    qs_q == QS_START |-> (cls_q == CL_EMPTY && len_q == '0 && !clip_q))
    else $error("field start with stale field data");

  a_clip_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clip_q |-> len_full) else $error("clip flag without full field");

  a_rec_reset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_vld_o && res_o.rec_end |=> fld_q == '0)
    else $error("field index not cleared at record end");

endmodule

/* rtl/core/csv_field_tokenizer_typer.sv */
// Top level: CSV field tokenizer and typer with input and output word registers.
//
// Usage:
//   Slave stream: one CSV byte per word in s_axis_tdata_i; s_axis_tuser_i set marks
//   end of input (the byte is then ignored). Master stream: zero or one result word
//   per input word: a content byte, a field end with class, size and index, or an
//   unterminated-quote error. m_axis_tuser_o holds the result kind, m_axis_tlast_o
//   is set on the word that ends a record.
//   cfg_we_i/cfg_wdata_i write the separator byte (reset value comma); write only
//   while the block is idle.
// Path: an accepted input word passes the input register, then the result register,
//   before its result word is valid on the master side.
// Throughput: 1 word per cycle when not stalled; each step is one pass of compare
//   and increment logic between the input register and the result register.
// Reset: quote state at field start, field index 0, both registers empty.
// Stall: while the result register is held, the input register still takes one
//   word; s_axis_tready_o drops once both are occupied. Nothing is lost.
module csv_field_tokenizer_typer #(
  parameter int MAX_FIELDS    = 128,
  parameter int MAX_FIELD_LEN = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,      // separator_char
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic [0:0]  s_axis_tuser_i,   // [0] end_of_input
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] out_byte, [15:8] field_number, [18:16] field_class, [29:19] field_size,
  // [30] length_clipped, [31] fields_overflow
  output logic [31:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,   // [1:0] result_kind
  output logic        m_axis_tlast_o    // record_end
);
  import csvt_pkg::*;

  logic       sep_we;
  logic [7:0] sep_val_q;
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_eoi_q;
  logic       out_vld_q;
  res_t       res_q;
  res_t       res;
  logic       res_vld;
  logic       adv;
  logic       step;

  assign adv             = !out_vld_q || m_axis_tready_i;
  assign step            = in_vld_q && adv;
  assign s_axis_tready_o = !in_vld_q || adv;
  assign sep_we          = cfg_we_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_val_q <= SEP_RESET;
    end else if (sep_we) begin
      sep_val_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_eoi_q  <= s_axis_tuser_i[0];
    end
  end

  csvt_core #(
    .MAX_FIELDS   (MAX_FIELDS),
    .MAX_FIELD_LEN(MAX_FIELD_LEN)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .eoi_i    (in_eoi_q),
    .sep_i    (sep_val_q),
    .res_vld_o(res_vld),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= step && res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_vld) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {res_q.ovf, res_q.clipped, res_q.size, res_q.cls,
                            res_q.fld_num, res_q.data};
  assign m_axis_tuser_o  = res_q.kind;
  assign m_axis_tlast_o  = res_q.rec_end;

endmodule

/* test/csv_field_tokenizer_typer_tb.sv */
// Testbench: CSV tokenizer stream checked word by word against a behavioral tokenizer.
module csv_field_tokenizer_typer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csvt_pkg::*;

  localparam int MAX_FIELDS    = 128;
  localparam int MAX_FIELD_LEN = 1024;
  localparam int HOLD_CYCLES   = 300;
  localparam res_t NO_RES      = '0;

  typedef struct {
    logic       eoi;
    logic [7:0] b;
    bit         typed;
    bit         yields;
    res_t       want;
  } dir_row_t;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        s_valid   = 1'b0;
  logic [7:0]  s_data    = 8'd0;
  logic [0:0]  s_user    = 1'b0;
  logic        m_ready   = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  // tokenizer state as the block should hold it
  qstate_e     tok_state = QS_START;
  cls_e        tok_cls   = CL_EMPTY;
  logic [10:0] tok_len   = '0;
  logic [7:0]  tok_field = '0;
  bit          tok_clip  = 1'b0;
  logic [7:0]  tok_sep   = SEP_RESET;

  res_t     expq[$];
  dir_row_t dir_rows[24];
  int       words_in, words_out, field_ends, quote_errs, seps_used, errors;
  bit       calm, hold_req;

  csv_field_tokenizer_typer #(
    .MAX_FIELDS    (MAX_FIELDS),
    .MAX_FIELD_LEN (MAX_FIELD_LEN)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic cls_e class_after(cls_e c, logic [7:0] b);
    bit alpha;
    bit num;
    alpha = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    num   = (b >= 8'h30 && b <= 8'h39);
    if (alpha) begin
      return (c == CL_EMPTY || c == CL_TEXT) ? CL_TEXT : CL_CODE;
    end
    if (num) begin
      case (c)
        CL_EMPTY: return CL_INT;
        CL_TEXT:  return CL_CODE;
        default:  return c;
      endcase
    end
    if (b == CH_DOT || b == CH_COMMA) begin
      case (c)
        CL_EMPTY, CL_INT:  return CL_FLOAT;
        CL_TEXT, CL_FLOAT: return CL_CODE;
        default:           return c;
      endcase
    end
    if (b == CH_DOLLAR) return (c == CL_EMPTY) ? CL_MONEY : CL_CODE;
    return c;
  endfunction

  function automatic res_t snapshot(kind_e k, logic [7:0] d, logic rec, logic clip);
    res_t r;
    r.kind    = k;
    r.data    = d;
    r.fld_num = tok_field;
    r.cls     = tok_cls;
    r.size    = tok_len;
    r.rec_end = rec;
    r.clipped = clip;
    r.ovf     = (tok_field >= MAX_FIELDS);
    return r;
  endfunction

  function automatic void restart_field();
    tok_state = QS_START;
    tok_cls   = CL_EMPTY;
    tok_len   = '0;
    tok_clip  = 1'b0;
  endfunction

  function automatic bit close_field(logic rec, output res_t r);
    r = snapshot(KIND_FIELD, 8'd0, rec, tok_clip);
    restart_field();
    if (rec) tok_field = '0;
    else if (tok_field < MAX_FIELDS) tok_field = tok_field + 8'd1;
    return 1'b1;
  endfunction

  function automatic bit keep_byte(logic [7:0] b, output res_t r);
    if (tok_len >= MAX_FIELD_LEN) begin
      tok_clip = 1'b1;
      return 1'b0;
    end
    tok_len = tok_len + 11'd1;
    tok_cls = class_after(tok_cls, b);
    r = snapshot(KIND_BYTE, b, 1'b0, 1'b0);
    return 1'b1;
  endfunction

  // returns 1 when the word yields a result word
  function automatic bit tokenize_byte(logic eoi, logic [7:0] b, output res_t r);
    r = NO_RES;
    if (eoi) begin
      if (tok_state == QS_QUOTED) begin
        r = snapshot(KIND_ERROR, 8'd0, 1'b1, tok_clip);
        restart_field();
        tok_field = '0;
        return 1'b1;
      end
      if (tok_state == QS_START && tok_field == 0) begin
        restart_field();
        return 1'b0;
      end
      return close_field(1'b1, r);
    end
    case (tok_state)
      QS_START: begin
        if (b == tok_sep) return close_field(1'b0, r);
        if (b == CH_NEWLINE) return close_field(1'b1, r);
        if (b == CH_QUOTE) begin
          tok_state = QS_QUOTED;
          return 1'b0;
        end
        tok_state = QS_PLAIN;
        return keep_byte(b, r);
      end
      QS_PLAIN: begin
        if (b == tok_sep) return close_field(1'b0, r);
        if (b == CH_NEWLINE) return close_field(1'b1, r);
        return keep_byte(b, r);
      end
      QS_QUOTED: begin
        if (b == CH_QUOTE) begin
          tok_state = QS_AFTER;
          return 1'b0;
        end
        return keep_byte(b, r);
      end
      default: begin
        if (b == tok_sep) return close_field(1'b0, r);
        if (b == CH_NEWLINE) return close_field(1'b1, r);
        if (b == CH_QUOTE) begin
          tok_state = QS_QUOTED;
          return keep_byte(b, r);
        end
        return 1'b0;
      end
    endcase
  endfunction

  task automatic feed_word(input logic eoi, input logic [7:0] b, input bit typed = 1'b0,
                           input bit yields = 1'b0, input res_t want = NO_RES);
    res_t r;
    bit   has;
    while (!calm && $urandom_range(99) < 29) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_user  <= eoi;
    do @(posedge clk_i); while (!s_axis_tready_o);
    words_in++;
    has = tokenize_byte(eoi, b, r);
    if (typed) begin
      has = yields;
      r   = want;
    end
    if (has) expq.push_back(r);
  endtask

  task automatic settle();
    s_valid <= 1'b0;
    while (expq.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_separator(input logic [7:0] v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    tok_sep = v;
    seps_used++;
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(9))
      0, 1:    return 8'h30 + 8'($urandom_range(9));
      2:       return 8'h41 + 8'($urandom_range(25));
      3:       return 8'h61 + 8'($urandom_range(25));
      4:       return CH_DOT;
      5:       return CH_COMMA;
      6:       return CH_DOLLAR;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] plain_safe(logic [7:0] c, bit first);
    if (c == tok_sep || c == CH_NEWLINE || (first && c == CH_QUOTE)) return 8'h5A;
    return c;
  endfunction

  task automatic send_field(input bit quoted);
    int         n;
    int         flavor;
    logic [7:0] c;
    n      = ($urandom_range(15) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
    flavor = $urandom_range(4);
    if (quoted) feed_word(1'b0, CH_QUOTE);
    for (int i = 0; i < n; i++) begin
      case (flavor)
        0:       c = 8'h30 + 8'($urandom_range(9));
        1:       c = (i == n / 2) ? CH_DOT : 8'h30 + 8'($urandom_range(9));
        2:       c = (i == 0) ? CH_DOLLAR : 8'h30 + 8'($urandom_range(9));
        3:       c = 8'h61 + 8'($urandom_range(25));
        default: c = pick_char();
      endcase
      if (quoted) begin
        feed_word(1'b0, c);
        if (c == CH_QUOTE) feed_word(1'b0, CH_QUOTE);
      end else begin
        feed_word(1'b0, plain_safe(c, i == 0));
      end
    end
    if (quoted) begin
      feed_word(1'b0, CH_QUOTE);
      // stray byte after the closing quote
      if ($urandom_range(7) == 0) feed_word(1'b0, plain_safe(pick_char(), 1'b1));
    end
  endtask

  task automatic send_record();
    int nf;
    nf = $urandom_range(1, 5);
    for (int f = 0; f < nf; f++) begin
      send_field($urandom_range(2) == 0);
      if (f < nf - 1) feed_word(1'b0, tok_sep);
    end
    case ($urandom_range(9))
      0: feed_word(1'b1, 8'($urandom));
      1: begin
        feed_word(1'b0, tok_sep);
        feed_word(1'b0, CH_QUOTE);
        feed_word(1'b0, pick_char());
        feed_word(1'b1, 8'($urandom));
      end
      default: feed_word(1'b0, CH_NEWLINE);
    endcase
  endtask

  task automatic run_random(input int words);
    int stop;
    stop = words_in + words;
    while (words_in < stop) begin
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 8)) feed_word($urandom_range(11) == 0, 8'($urandom_range(255)));
      end else begin
        send_record();
      end
    end
  endtask

  // sink: random back-pressure plus one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 29);
    end
  end

  function automatic void check_field(string nm, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      words_out++;
      if (m_axis_tuser_o == KIND_FIELD) field_ends++;
      if (m_axis_tuser_o == KIND_ERROR) quote_errs++;
      if (expq.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, expected nothing, got kind %0d data %h",
                 $time, m_axis_tuser_o, m_axis_tdata_o);
      end else begin
        want = expq.pop_front();
        check_field("result_kind", want.kind, m_axis_tuser_o);
        check_field("out_byte", want.data, m_axis_tdata_o[7:0]);
        check_field("field_number", want.fld_num, m_axis_tdata_o[15:8]);
        check_field("field_class", want.cls, m_axis_tdata_o[18:16]);
        check_field("field_size", want.size, m_axis_tdata_o[29:19]);
        check_field("length_clipped", want.clipped, m_axis_tdata_o[30]);
        check_field("fields_overflow", want.ovf, m_axis_tdata_o[31]);
        check_field("record_end", want.rec_end, m_axis_tlast_o);
      end
    end
  end

  initial begin
    dir_rows = '{
      '{1'b1, 8'h00,      1'b1, 1'b0, NO_RES},
      '{1'b0, CH_NEWLINE, 1'b1, 1'b1,
        '{KIND_FIELD, 8'd0, 8'd0, CL_EMPTY, 11'd0, 1'b1, 1'b0, 1'b0}},
      '{1'b0, CH_COMMA,   1'b1, 1'b1,
        '{KIND_FIELD, 8'd0, 8'd0, CL_EMPTY, 11'd0, 1'b0, 1'b0, 1'b0}},
      '{1'b0, CH_DOLLAR,  1'b1, 1'b1,
        '{KIND_BYTE, CH_DOLLAR, 8'd1, CL_MONEY, 11'd1, 1'b0, 1'b0, 1'b0}},
      '{1'b0, 8'h31,      1'b0, 1'b0, NO_RES},
      '{1'b0, 8'h78,      1'b0, 1'b0, NO_RES},
      '{1'b0, CH_COMMA,   1'b0, 1'b0, NO_RES},
      '{1'b0, 8'h37,      1'b0, 1'b0, NO_RES},
      '{1'b0, 8'h51,      1'b0, 1'b0, NO_RES},
      '{1'b0, CH_COMMA,   1'b0, 1'b0, NO_RES},
      '{1'b0, CH_QUOTE,   1'b1, 1'b0, NO_RES},
      '{1'b0, 8'h61,      1'b0, 1'b0, NO_RES},
      '{1'b0, CH_QUOTE,   1'b1, 1'b0, NO_RES},
      '{1'b0, CH_QUOTE,   1'b0, 1'b0, NO_RES},
      '{1'b0, CH_QUOTE,   1'b1, 1'b0, NO_RES},
      '{1'b0, 8'h7A,      1'b1, 1'b0, NO_RES},
      '{1'b0, CH_COMMA,   1'b0, 1'b0, NO_RES},
      '{1'b0, CH_QUOTE,   1'b1, 1'b0, NO_RES},
      '{1'b0, CH_NEWLINE, 1'b0, 1'b0, NO_RES},
      '{1'b0, CH_COMMA,   1'b0, 1'b0, NO_RES},
      '{1'b1, 8'hFF,      1'b0, 1'b0, NO_RES},
      '{1'b0, 8'hFF,      1'b0, 1'b0, NO_RES},
      '{1'b0, CH_DOT,     1'b0, 1'b0, NO_RES},
      '{1'b1, 8'h00,      1'b0, 1'b0, NO_RES}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset separator, directed words
    foreach (dir_rows[i]) begin
      feed_word(dir_rows[i].eoi, dir_rows[i].b, dir_rows[i].typed, dir_rows[i].yields,
                dir_rows[i].want);
    end
    run_random(90);

    // field count saturation, starting from record start
    feed_word(1'b1, 8'h00);
    for (int i = 0; i < MAX_FIELDS + 3; i++) begin
      if (i % 32 == 5) feed_word(1'b0, 8'h39);
      feed_word(1'b0, tok_sep);
    end
    feed_word(1'b0, CH_NEWLINE);
    settle();

    set_separator(8'h00);
    hold_req = 1'b1;
    run_random(80);
    settle();

    set_separator(8'hFF);
    run_random(80);
    settle();

    calm = 1'b1;
    set_separator(8'h3B);
    run_random(80);
    settle();
    calm = 1'b0;

    set_separator(CH_NEWLINE);
    run_random(50);
    settle();

    set_separator(CH_QUOTE);
    run_random(50);
    settle();

    set_separator(8'($urandom_range(255)));
    run_random(50);
    settle();

    $display("Run covered %0d input words, %0d result words, %0d field ends,",
             words_in, words_out, field_ends);
    $display("%0d open-quote errors, %0d separator writes and a field-count overflow record.",
             quote_errs, seps_used);
    if (errors == 0 && expq.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/csvt_pkg.sv
rtl/core/csvt_core.sv
rtl/core/csv_field_tokenizer_typer.sv
test/csv_field_tokenizer_typer_tb.sv
